[rtl/edl_pkg.sv]
package edl_pkg;

    localparam int TIME_W        = 32;
    localparam int ID_W          = 16;
    localparam int BTN_W         = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int LOG_SLOTS_DEF = 8;

    localparam logic [ID_W-1:0]   FREE_ID           = 16'hFFFF;
    localparam logic [TIME_W-1:0] TIME_MAX          = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] REPEAT_WINDOW_RST = 32'd500;
    localparam logic [BTN_W-1:0]  EMPTY_BUTTON_RST  = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPEAT_WINDOW = 1'b0,
        REG_EMPTY_BUTTON  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   id;
        logic [BTN_W-1:0]  button;
    } slot_t;

    localparam slot_t SLOT_RST = '{stamp: '0, id: FREE_ID, button: EMPTY_BUTTON_RST};

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic last_addr;
        logic out_free;
    } sts_t;

endpackage

[rtl/edl_in_if.sv]
interface edl_in_if;

    logic                       valid;
    logic                       ready;
    logic [edl_pkg::TIME_W-1:0] event_time;
    logic [edl_pkg::ID_W-1:0]   event_id;
    logic [edl_pkg::BTN_W-1:0]  event_button;

    modport source (output valid, output event_time, output event_id, output event_button,
                    input ready);
    modport sink (input valid, input event_time, input event_id, input event_button,
                  output ready);

endinterface

[rtl/edl_out_if.sv]
interface edl_out_if;

    logic valid;
    logic ready;
    logic added;
    logic log_error;

    modport source (output valid, output added, output log_error, input ready);
    modport sink (input valid, input added, input log_error, output ready);

endinterface

[rtl/edl_datapath.sv]
module edl_datapath #(
    parameter int LOG_SLOTS = edl_pkg::LOG_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  edl_pkg::cmd_t                  cmd,
    output edl_pkg::sts_t                  sts,
    input  logic                           in_valid,
    input  logic [edl_pkg::TIME_W-1:0]     event_time,
    input  logic [edl_pkg::ID_W-1:0]       event_id,
    input  logic [edl_pkg::BTN_W-1:0]      event_button,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           added,
    output logic                           log_error,
    input  logic                           cfg_we,
    input  logic [edl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [edl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import edl_pkg::*;

    localparam int IDX_W = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOG_SLOTS - 1);

    slot_t mem [LOG_SLOTS];

    logic [LOG_SLOTS-1:0] slot_vld_reg;
    logic [TIME_W-1:0]    window_reg;
    logic [BTN_W-1:0]     empty_code_reg;
    slot_t                ev_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 eval_pend_reg;
    slot_t                rd_data_reg;
    logic                 rd_vld_reg;
    logic                 dup_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 old_found_reg;
    logic [IDX_W-1:0]     old_idx_reg;
    logic [TIME_W-1:0]    old_time_reg;
    logic                 out_valid_reg;
    logic                 added_reg;
    logic                 err_reg;

    slot_t             cur_slot;
    logic [TIME_W-1:0] age;
    logic              is_free;
    logic              is_dup;
    logic              is_older;
    logic              do_write;
    logic [IDX_W-1:0]  wr_idx;

    always_comb
    begin
        cur_slot = rd_vld_reg ? rd_data_reg : SLOT_RST;
        age      = ev_reg.stamp - cur_slot.stamp;
        is_free  = (cur_slot.button == empty_code_reg) && (cur_slot.id == FREE_ID);
        is_dup   = !is_free && (age < window_reg) && (cur_slot.id == ev_reg.id)
                   && (cur_slot.button == ev_reg.button);
        is_older = !is_free && !is_dup && (cur_slot.stamp < old_time_reg);
        wr_idx   = free_found_reg ? free_idx_reg : old_idx_reg;
        do_write = cmd.finish && !dup_reg && (free_found_reg || old_found_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= REPEAT_WINDOW_RST;
            empty_code_reg <= EMPTY_BUTTON_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_REPEAT_WINDOW: window_reg     <= cfg_wdata[TIME_W-1:0];
                REG_EMPTY_BUTTON:  empty_code_reg <= cfg_wdata[BTN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_idx] <= ev_reg;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
        end
        else if (do_write)
        begin
            slot_vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ev_reg <= '{stamp: event_time, id: event_id, button: event_button};
        end
        if (cmd.issue)
        begin
            rd_vld_reg   <= slot_vld_reg[addr_reg];
            eval_idx_reg <= addr_reg;
        end
        if (cmd.load)
        begin
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            old_found_reg  <= 1'b0;
            old_idx_reg    <= '0;
            old_time_reg   <= TIME_MAX;
        end
        else if (eval_pend_reg && !dup_reg)
        begin
            priority if (is_free)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= eval_idx_reg;
            end
            else if (is_dup)
            begin
                dup_reg <= 1'b1;
            end
            else if (is_older)
            begin
                old_found_reg <= 1'b1;
                old_idx_reg   <= eval_idx_reg;
                old_time_reg  <= cur_slot.stamp;
            end
        end
        if (cmd.finish)
        begin
            added_reg <= !dup_reg && (free_found_reg || old_found_reg);
            err_reg   <= !dup_reg && !free_found_reg && !old_found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            eval_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eval_pend_reg <= cmd.issue;
            if (cmd.load)
            begin
                addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.in_valid  = in_valid;
    assign sts.last_addr = (addr_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign added     = added_reg;
    assign log_error = err_reg;

endmodule

[rtl/edl_ctrl.sv]
module edl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  edl_pkg::sts_t sts,
    output edl_pkg::cmd_t cmd,
    output logic          in_ready
);

    import edl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = sts.in_valid;
                if (sts.in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

[rtl/event_dedup_log.sv]
// Channel     Role    Payload
// event_ch    sink    event_time, event_id, event_button
// result_ch   source  added, log_error
// cfg port    write   cfg_we, cfg_index, cfg_wdata
//
// Each event is loaded, then scanned against the slot memory one slot per cycle, then passes
// a drain state and a finish state, in which its result is registered.
// A new event is taken while an earlier result still waits on result_ch.
// Reset marks every slot free through per-slot valid bits, so no clearing pass runs.
// A stalled result holds the next event in the finish state until result_ch takes it.
module event_dedup_log #(
    parameter int LOG_SLOTS = edl_pkg::LOG_SLOTS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    edl_in_if.sink                        event_ch,
    edl_out_if.source                     result_ch,
    input logic                           cfg_we,
    input logic [edl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [edl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import edl_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    edl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    edl_datapath #(
        .LOG_SLOTS (LOG_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_valid     (event_ch.valid),
        .event_time   (event_ch.event_time),
        .event_id     (event_ch.event_id),
        .event_button (event_ch.event_button),
        .out_ready    (result_ch.ready),
        .out_valid    (result_ch.valid),
        .added        (result_ch.added),
        .log_error    (result_ch.log_error),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    assign event_ch.ready = in_ready;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import edl_pkg::*;

    localparam int SLOTS       = LOG_SLOTS_DEF;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 113;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 250;
    localparam int SETTLE      = SLOTS + 4;

    typedef struct packed {
        logic added;
        logic log_error;
    } verdict_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   id;
        logic [BTN_W-1:0]  button;
        logic              typed;
        verdict_t          want;
    } dir_row_t;

    // A typed verdict is {added, log_error}; untyped rows take the predicted one.
    dir_row_t dir_rows [16] = '{
        '{32'd100,        16'h0001, 8'h01, 1'b1, 2'b10},
        '{32'd599,        16'h0001, 8'h01, 1'b1, 2'b00},
        '{32'd600,        16'h0001, 8'h01, 1'b1, 2'b10},
        '{32'd0,          16'hFFFF, 8'h00, 1'b0, 2'b00},
        '{32'd0,          16'hFFFF, 8'h00, 1'b0, 2'b00},
        '{32'hFFFF_FFFF,  16'h0000, 8'hFF, 1'b0, 2'b00},
        '{32'hFFFF_FFFF,  16'hFFFF, 8'h01, 1'b0, 2'b00},
        '{32'hFFFF_FFFF,  16'hFFFF, 8'h02, 1'b0, 2'b00},
        '{32'hFFFF_FFFF,  16'hFFFF, 8'h03, 1'b0, 2'b00},
        '{32'hFFFF_FFFF,  16'hFFFF, 8'h04, 1'b0, 2'b00},
        '{32'hFFFF_FFFF,  16'hFFFF, 8'h05, 1'b0, 2'b00},
        '{32'hFFFF_FFFF,  16'hFFFF, 8'h80, 1'b0, 2'b00},
        '{32'hFFFF_FFFF,  16'hFFFF, 8'h81, 1'b0, 2'b00},
        '{32'd0,          16'h1234, 8'h42, 1'b1, 2'b01},
        '{32'd5,          16'h0000, 8'hFF, 1'b0, 2'b00},
        '{32'h8000_0000,  16'hAAAA, 8'h55, 1'b1, 2'b01}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    edl_in_if  event_ch ();
    edl_out_if result_ch ();

    event_dedup_log u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (event_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    slot_t             log_model [SLOTS];
    logic [TIME_W-1:0] window_reg;
    logic [BTN_W-1:0]  empty_code;
    verdict_t          outcome_q [$];

    int n_fail      = 0;
    int n_results   = 0;
    int n_events    = 0;
    int n_added     = 0;
    int n_dup       = 0;
    int n_err       = 0;
    int n_settings  = 0;
    int idle_cycles = 0;
    bit src_gaps    = 1'b1;
    bit snk_gaps    = 1'b1;

    function automatic bit slot_free(slot_t s, logic [BTN_W-1:0] code);
        return s.button == code && s.id == FREE_ID;
    endfunction

    function automatic verdict_t log_event(logic [TIME_W-1:0] ev_time,
                                           logic [ID_W-1:0] ev_id,
                                           logic [BTN_W-1:0] ev_btn);
        int                free_idx;
        int                oldest_idx;
        logic [TIME_W-1:0] oldest;
        logic [TIME_W-1:0] age;
        free_idx   = -1;
        oldest_idx = -1;
        oldest     = TIME_MAX;
        for (int k = 0; k < SLOTS; k++)
        begin
            age = ev_time - log_model[k].stamp;
            if (slot_free(log_model[k], empty_code))
                free_idx = k;
            else if (age < window_reg && log_model[k].id == ev_id &&
                     log_model[k].button == ev_btn)
                return '{added: 1'b0, log_error: 1'b0};
            else if (log_model[k].stamp < oldest)
            begin
                oldest     = log_model[k].stamp;
                oldest_idx = k;
            end
        end
        if (free_idx < 0)
            free_idx = oldest_idx;
        if (free_idx < 0)
            return '{added: 1'b0, log_error: 1'b1};
        log_model[free_idx] = '{stamp: ev_time, id: ev_id, button: ev_btn};
        return '{added: 1'b1, log_error: 1'b0};
    endfunction

    task automatic offer_event(input logic [TIME_W-1:0] ev_time, input logic [ID_W-1:0] ev_id,
                               input logic [BTN_W-1:0] ev_btn, input bit typed,
                               input verdict_t want);
        int       gap;
        verdict_t predicted;
        verdict_t pushed;
        gap = src_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            event_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        event_ch.valid        <= 1'b1;
        event_ch.event_time   <= ev_time;
        event_ch.event_id     <= ev_id;
        event_ch.event_button <= ev_btn;
        do
            @(posedge clk);
        while (!(event_ch.valid && event_ch.ready));
        predicted = log_event(ev_time, ev_id, ev_btn);
        pushed = typed ? want : predicted;
        outcome_q.push_back(pushed);
        n_events++;
        if (pushed.added)
            n_added++;
        else if (pushed.log_error)
            n_err++;
        else
            n_dup++;
        @(negedge clk);
    endtask

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if ((event_ch.valid && event_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int       stall;
        verdict_t want;
        bit       held;
        held = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = snk_gaps ? $urandom_range(0, 9) : 0;
            // One long hold lets the block fill up and back-pressure the event channel.
            if (!held && n_results >= HOLD_AT)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
            n_results++;
            if (outcome_q.size() == 0)
            begin
                n_fail++;
                $display("%0t: unexpected result, expected none, got added %0b log_error %0b",
                         $time, result_ch.added, result_ch.log_error);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (result_ch.added !== want.added)
                begin
                    n_fail++;
                    $display("%0t: added mismatch, expected %0b, got %0b",
                             $time, want.added, result_ch.added);
                end
                if (result_ch.log_error !== want.log_error)
                begin
                    n_fail++;
                    $display("%0t: log_error mismatch, expected %0b, got %0b",
                             $time, want.log_error, result_ch.log_error);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        slot_t             pick;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] delta;
        logic [ID_W-1:0]   id;
        logic [BTN_W-1:0]  btn;
        logic [TIME_W-1:0] new_window;
        logic [BTN_W-1:0]  new_code;
        bit                jammed;
        bit                saturate;
        int                r;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_REPEAT_WINDOW;
        cfg_wdata             = '0;
        event_ch.valid        = 1'b0;
        event_ch.event_time   = '0;
        event_ch.event_id     = '0;
        event_ch.event_button = '0;
        window_reg            = REPEAT_WINDOW_RST;
        empty_code            = EMPTY_BUTTON_RST;
        foreach (log_model[k])
            log_model[k] = SLOT_RST;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer_event(dir_rows[i].stamp, dir_rows[i].id, dir_rows[i].button,
                        dir_rows[i].typed, dir_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            event_ch.valid <= 1'b0;
            while (outcome_q.size() != 0)
                @(negedge clk);
            repeat (SETTLE) @(negedge clk);

            saturate = (p == 2);
            src_gaps = (p % 3 != 1);
            snk_gaps = (p % 4 != 2);
            case (p)
                0:
                begin
                    new_window = '0;
                    new_code   = 8'h80;
                end
                1:
                begin
                    new_window = TIME_MAX;
                    new_code   = 8'h00;
                end
                2:
                begin
                    new_window = '0;
                    new_code   = 8'h00;
                end
                4:
                begin
                    new_window = $urandom_range(1, 4000);
                    new_code   = 8'hFF;
                end
                default:
                begin
                    r = $urandom_range(0, 3);
                    new_window = (r == 0) ? REPEAT_WINDOW_RST :
                                 (r == 1) ? $urandom_range(1, 4000) :
                                 (r == 2) ? 32'd1 : $urandom;
                    new_code = BTN_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom);
                end
            endcase

            // A log full of maximal times never accepts a write again; the empty code
            // is moved onto a stored button so that one of those slots becomes free.
            jammed = 1'b1;
            foreach (log_model[k])
                if (slot_free(log_model[k], new_code) || log_model[k].stamp != TIME_MAX)
                    jammed = 1'b0;
            if (jammed)
                foreach (log_model[k])
                    if (log_model[k].id == FREE_ID)
                        new_code = log_model[k].button;

            cfg_we    <= 1'b1;
            cfg_index <= REG_REPEAT_WINDOW;
            cfg_wdata <= new_window;
            @(negedge clk);
            cfg_index <= REG_EMPTY_BUTTON;
            cfg_wdata <= {{(CFG_DATA_W - BTN_W){1'b0}}, new_code};
            @(negedge clk);
            cfg_we     <= 1'b0;
            window_reg  = new_window;
            empty_code  = new_code;
            n_settings++;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r    = $urandom_range(0, 99);
                pick = log_model[$urandom_range(0, SLOTS - 1)];
                if (saturate)
                begin
                    t   = (r < 70) ? TIME_MAX : $urandom;
                    id  = FREE_ID;
                    btn = BTN_W'($urandom_range(1, 3));
                end
                else if (r < 40)
                begin
                    case ($urandom_range(0, 5))
                        0:       delta = '0;
                        1:       delta = window_reg - 1;
                        2:       delta = window_reg;
                        3:       delta = window_reg + 1;
                        4:       delta = $urandom_range(0, 1000);
                        default: delta = $urandom;
                    endcase
                    t   = pick.stamp + delta;
                    id  = pick.id;
                    btn = pick.button;
                    if (r >= 37)
                        btn = btn ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
                    else if (r >= 34)
                        id = id ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
                end
                else if (r < 50)
                begin
                    t   = $urandom;
                    id  = FREE_ID;
                    btn = r[0] ? empty_code : BTN_W'($urandom_range(0, 3));
                end
                else if (r < 54)
                begin
                    t   = TIME_MAX;
                    id  = FREE_ID;
                    btn = BTN_W'($urandom_range(0, 3));
                end
                else
                begin
                    t   = r[0] ? $urandom : $urandom_range(0, 2000);
                    id  = ID_W'(r[1] ? $urandom : $urandom_range(0, 15));
                    btn = BTN_W'(r[2] ? $urandom : $urandom_range(0, 3));
                end
                offer_event(t, id, btn, 1'b0, '0);
            end
        end

        event_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("summary: %0d events under %0d register settings after the reset values",
                 n_events, n_settings);
        $display("summary: %0d stored, %0d rejected as repeats, %0d rejected with log error",
                 n_added, n_dup, n_err);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
